### design/table_keyed_stream_cipher_hash_macros.svh
// ----------------------------------------------------------------------------
// table keyed stream cipher hash - assertion macros
// concurrent assertion shorthands used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef TABLE_KEYED_STREAM_CIPHER_HASH_MACROS_SVH
`define TABLE_KEYED_STREAM_CIPHER_HASH_MACROS_SVH

// same-cycle implication, disabled in reset
`define TKH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define TKH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/tkh_pkg.sv
// ----------------------------------------------------------------------------
// tkh_pkg
// shared types and constants of the table keyed stream cipher and hash
// ----------------------------------------------------------------------------
package tkh_pkg;

	// commands
	localparam logic [1:0] CMD_ENCRYPT = 2'd0;
	localparam logic [1:0] CMD_DECRYPT = 2'd1;
	localparam logic [1:0] CMD_HASH    = 2'd2;

	// result kinds
	localparam logic KIND_CIPHER = 1'b0;
	localparam logic KIND_HASH   = 1'b1;

	// key table geometry
	localparam int TABLE_DEPTH = 1280;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	localparam logic [2:0]  MAX_SECTION    = 3'd4;
	localparam logic [2:0]  CIPHER_SECTION = 3'd4;
	localparam logic [31:0] SEED_INIT      = 32'hEEEEEEEE;
	localparam logic [31:0] ACC_A_INIT     = 32'h7FED7FED;
	localparam logic [31:0] KEY_ADD        = 32'h11111111;

	typedef struct packed {
		logic [1:0]  command;
		logic        first;
		logic        last;
		logic [31:0] cipher_key;
		logic [31:0] data_word;
		logic [7:0]  data_byte;
		logic [2:0]  hash_section;
		logic        fold_case;
	} tkh_in_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        result_kind;
	} tkh_out_t;

	// classified job passed from front to back
	typedef struct packed {
		logic        op_hash;
		logic        op_decrypt;
		logic        first;
		logic        last;
		logic [31:0] key;
		logic [31:0] word;
		logic [7:0]  hbyte;
		logic [31:0] tword;
	} tkh_job_t;

	// table write port
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} tkh_wr_t;

endpackage

### design/tkh_ram.sv
// ----------------------------------------------------------------------------
// tkh_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tkh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1280
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/tkh_keygen.sv
// ----------------------------------------------------------------------------
// tkh_keygen
// fills the key table after reset from the congruential generator
// ----------------------------------------------------------------------------
module tkh_keygen (
	input  logic            clk,
	input  logic            arst_n,
	output logic            busy,
	output tkh_pkg::tkh_wr_t wr
);

	import tkh_pkg::*;

	localparam logic [21:0] GEN_START = 22'h100001;
	localparam logic [24:0] GEN_M1    = 25'h2AAAAB;
	localparam logic [24:0] GEN_M2    = GEN_M1 * 2;
	localparam logic [24:0] GEN_M3    = GEN_M1 * 3;
	localparam logic [24:0] GEN_M4    = GEN_M1 * 4;
	localparam logic [1:0]  SUB_LAST  = 2'd2;
	localparam logic [2:0]  J_LAST    = 3'd4;
	localparam logic [7:0]  I_LAST    = 8'hFF;

	// one factor of 5 of the multiply by 125, reduced mod the generator modulus
	function automatic logic [21:0] mul5_mod(input logic [21:0] x, input logic [1:0] add);
		logic [24:0] y;
		logic [24:0] r;
		y = ({3'd0, x} << 2) + {3'd0, x} + {23'd0, add};
		if (y >= GEN_M4) begin
			r = y - GEN_M4;
		end else if (y >= GEN_M3) begin
			r = y - GEN_M3;
		end else if (y >= GEN_M2) begin
			r = y - GEN_M2;
		end else if (y >= GEN_M1) begin
			r = y - GEN_M1;
		end else begin
			r = y;
		end
		return r[21:0];
	endfunction

	logic        busy_q;
	logic [21:0] gen_q;
	logic [1:0]  sub_q;
	logic        half_q;
	logic [7:0]  i_q;
	logic [2:0]  j_q;
	logic [15:0] hi_q;
	logic [21:0] gen_next;

	always_comb begin
		gen_next = mul5_mod(gen_q, (sub_q == SUB_LAST) ? 2'd3 : 2'd0);
		busy     = busy_q;
		wr.we    = busy_q && (sub_q == SUB_LAST) && half_q;
		wr.addr  = {j_q, i_q};
		wr.data  = {hi_q, gen_next[15:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			gen_q  <= GEN_START;
			sub_q  <= '0;
			half_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else if (busy_q) begin
			gen_q <= gen_next;
			if (sub_q == SUB_LAST) begin
				sub_q  <= '0;
				half_q <= !half_q;
				if (half_q) begin
					if (j_q == J_LAST) begin
						j_q <= '0;
						if (i_q == I_LAST) begin
							busy_q <= 1'b0;
						end else begin
							i_q <= i_q + 8'd1;
						end
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	// high half of the entry under construction
	always_ff @(posedge clk) begin
		if (busy_q && (sub_q == SUB_LAST) && !half_q) begin
			hi_q <= gen_next[15:0];
		end
	end

endmodule

### design/tkh_front.sv
// ----------------------------------------------------------------------------
// tkh_front
// accepts beats, keeps key and section, issues the table read
// ----------------------------------------------------------------------------
module tkh_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fill_busy,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  tkh_pkg::tkh_in_t            item,
	input  logic                        q_full,
	output logic                        push,
	output tkh_pkg::tkh_job_t           job,
	output logic                        rd_en,
	output logic [tkh_pkg::ADDR_W-1:0]  rd_addr,
	input  logic [31:0]                 rd_data
);

	import tkh_pkg::*;

	logic        s1_valid_q;
	tkh_job_t    job_s1;
	logic [31:0] running_key_q;
	logic [2:0]  active_section_q;

	logic        accept;
	logic        is_cipher;
	logic        is_hash;
	logic [31:0] key_use;
	logic [31:0] key_next;
	logic [2:0]  sec_use;
	logic [2:0]  sec_clamp;
	logic [7:0]  c_fold;

	always_comb begin
		item_ready = !fill_busy && (!s1_valid_q || !q_full);
		accept     = item_valid && item_ready;
		is_cipher  = (item.command == CMD_ENCRYPT) || (item.command == CMD_DECRYPT);
		is_hash    = (item.command == CMD_HASH);
		key_use    = item.first ? item.cipher_key : running_key_q;
		key_next   = (((~key_use) << 21) + KEY_ADD) | (key_use >> 11);
		sec_use    = item.first ? item.hash_section : active_section_q;
		sec_clamp  = (sec_use > MAX_SECTION) ? MAX_SECTION : sec_use;
		if (item.fold_case && (item.data_byte > 8'h60) && (item.data_byte < 8'h7B)) begin
			c_fold = item.data_byte - 8'h20;
		end else begin
			c_fold = item.data_byte;
		end
		rd_en   = accept && (is_cipher || is_hash);
		rd_addr = is_hash ? {sec_clamp, c_fold} : {CIPHER_SECTION, key_use[7:0]};
		push    = s1_valid_q && !q_full;
		job       = job_s1;
		job.tword = rd_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q       <= 1'b0;
			running_key_q    <= '0;
			active_section_q <= '0;
		end else begin
			if (push) begin
				s1_valid_q <= 1'b0;
			end
			if (rd_en) begin
				s1_valid_q <= 1'b1;
			end
			if (accept && is_cipher) begin
				running_key_q <= key_next;
			end
			if (accept && is_hash) begin
				active_section_q <= sec_use;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			job_s1.op_hash    <= is_hash;
			job_s1.op_decrypt <= (item.command == CMD_DECRYPT);
			job_s1.first      <= item.first;
			job_s1.last       <= item.last;
			job_s1.key        <= key_use;
			job_s1.word       <= item.data_word;
			job_s1.hbyte      <= c_fold;
			job_s1.tword      <= '0;
		end
	end

endmodule

### design/tkh_queue.sv
// ----------------------------------------------------------------------------
// tkh_queue
// small register queue of classified jobs between front and back
// ----------------------------------------------------------------------------
module tkh_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tkh_pkg::tkh_job_t din,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output tkh_pkg::tkh_job_t head
);

	import tkh_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	tkh_job_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_ONE;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

### design/tkh_back.sv
// ----------------------------------------------------------------------------
// tkh_back
// runs cipher and hash updates and holds the result register
// ----------------------------------------------------------------------------
module tkh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  tkh_pkg::tkh_job_t head,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output tkh_pkg::tkh_out_t result
);

	import tkh_pkg::*;

	logic [31:0] seed_q;
	logic [31:0] acc_a_q;
	logic [31:0] acc_b_q;
	logic        res_valid_q;
	tkh_out_t    res_q;

	logic        needs_out;
	logic [31:0] s_base;
	logic [31:0] s_mix;
	logic [31:0] c_out;
	logic [31:0] plain;
	logic [31:0] seed_next;
	logic [31:0] a_base;
	logic [31:0] b_base;
	logic [31:0] a_next;
	logic [31:0] b_next;

	always_comb begin
		needs_out = !head.op_hash || head.last;
		pop       = !q_empty && (!needs_out || !res_valid_q || result_ready);

		// cipher word
		s_base    = head.first ? SEED_INIT : seed_q;
		s_mix     = s_base + head.tword;
		c_out     = head.word ^ (head.key + s_mix);
		plain     = head.op_decrypt ? c_out : head.word;
		seed_next = plain + s_mix + (s_mix << 5) + 32'd3;

		// hash byte
		a_base = head.first ? ACC_A_INIT : acc_a_q;
		b_base = head.first ? SEED_INIT : acc_b_q;
		a_next = head.tword ^ (a_base + b_base);
		b_next = {24'd0, head.hbyte} + a_next + b_base + (b_base << 5) + 32'd3;

		result_valid = res_valid_q;
		result       = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			seed_q      <= SEED_INIT;
			acc_a_q     <= ACC_A_INIT;
			acc_b_q     <= SEED_INIT;
		end else begin
			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				if (needs_out) begin
					res_valid_q <= 1'b1;
				end
				if (head.op_hash) begin
					acc_a_q <= a_next;
					acc_b_q <= b_next;
				end else begin
					seed_q <= seed_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && needs_out) begin
			res_q.result_value <= head.op_hash ? a_next : c_out;
			res_q.result_kind  <= head.op_hash ? KIND_HASH : KIND_CIPHER;
		end
	end

endmodule

### design/table_keyed_stream_cipher_hash.sv
// ----------------------------------------------------------------------------
// table_keyed_stream_cipher_hash
// stream cipher over 32-bit words and byte string hash keyed by a 1280-word table
// ----------------------------------------------------------------------------
//
//   channel   side  handshake                    beat
//   item      in    item_valid / item_ready      tkh_in_t  (command, key, data)
//   result    out   result_valid / result_ready  tkh_out_t (value, kind)
//
// one beat per cycle sustained while the job queue has room; a result
// leaves the result register after the table read, queue and back-end update
// after reset the key table is filled by the generator: 1280 entries of two
// generator steps each, with item_ready low until the fill is done
// the job queue holds QUEUE_DEPTH jobs, so the front keeps taking beats
// while a result waits; hash bytes that are not last drain without a result
//
module table_keyed_stream_cipher_hash #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tkh_pkg::tkh_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output tkh_pkg::tkh_out_t result
);

	import tkh_pkg::*;

	`include "table_keyed_stream_cipher_hash_macros.svh"

	// fill sequencer and table write port
	logic    fill_busy;
	tkh_wr_t wr;

	// table read port, owned by the front end
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [31:0]       rd_data;

	// front to queue to back
	logic     q_push;
	logic     q_full;
	logic     q_empty;
	logic     q_pop;
	tkh_job_t q_din;
	tkh_job_t q_head;

	tkh_keygen u_keygen (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (fill_busy),
		.wr     (wr)
	);

	// key table: sections 0..3 feed the hash, section 4 feeds both
	tkh_ram #(
		.WIDTH (32),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// front end: running key and hash section live here, so the table
	// address of each beat is known the cycle it is taken
	tkh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fill_busy  (fill_busy),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.push       (q_push),
		.job        (q_din),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	tkh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (q_head)
	);

	// back end: seed and hash accumulators, result register
	tkh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// no beat is taken while the table is still being filled
	`TKH_ASSERT_IMPL(a_no_take_in_fill, clk, arst_n, fill_busy, !item_ready, "beat taken during table fill")
	// the fill runs once after reset
	`TKH_ASSERT_NEXT(a_fill_once, clk, arst_n, !fill_busy, !fill_busy, "table fill restarted")
	// the table is read only after the fill, never written after it
	`TKH_ASSERT_IMPL(a_no_late_write, clk, arst_n, !fill_busy, !wr.we, "table write after fill")
	// nothing can reach the result register before the fill ends
	`TKH_ASSERT_IMPL(a_no_result_in_fill, clk, arst_n, fill_busy, !result_valid && q_empty, "result during table fill")

endmodule
